// ===== src/pra_pkg.sv =====
// Shared types and constants of the page run allocator.
package pra_pkg;

	localparam int MAP_PAGES_DEF = 4096;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int SHIFT_W    = 5;
	localparam int COUNT_W    = 13;
	localparam int PG_W       = 26;
	localparam int STAT_W     = 13;

	localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd8;
	localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd16;
	localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd12;
	localparam logic [COUNT_W-1:0] COUNT_RST = 13'd4096;

	localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT  = 2'd2;

	localparam logic [1:0] KIND_BEST = 2'd0;
	localparam logic [1:0] KIND_AT   = 2'd1;
	localparam logic [1:0] KIND_FREE = 2'd2;
	localparam logic [1:0] KIND_STAT = 2'd3;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_BAD     = 2'd2;

	localparam logic [2:0] STAT_FREE_PAGES = 3'd0;
	localparam logic [2:0] STAT_LARGE_FREE = 3'd1;
	localparam logic [2:0] STAT_SMALL_FREE = 3'd2;
	localparam logic [2:0] STAT_LARGE_ALLOC = 3'd3;
	localparam logic [2:0] STAT_SMALL_ALLOC = 3'd4;
	localparam logic [2:0] STAT_ALLOC_RUNS = 3'd5;
	localparam logic [2:0] STAT_FREE_RUNS = 3'd6;

	typedef enum logic [3:0] {
		S_FILL,
		S_IDLE,
		S_PREP,
		S_CHECK,
		S_SCAN,
		S_CLOSE,
		S_DECIDE,
		S_WRITE,
		S_RESP,
		S_STAT
	} state_t;

	typedef enum logic [1:0] {
		RES_OK,
		RES_NOSPACE,
		RES_BAD,
		RES_STAT
	} res_t;

	typedef struct packed {
		logic       capture;
		logic       prep;
		logic       scan_init;
		logic       scan_en;
		logic       close_run;
		logic       wr_init;
		logic       wr_en;
		logic       fill_init;
		logic       commit;
		logic       out_load;
		res_t       res;
		logic [2:0] stat_idx;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       bad;
		logic       scan_done;
		logic       wr_done;
		logic       found;
		logic       conflict;
		logic       out_free;
		logic       cfg_restart;
	} sts_t;

endpackage

// ===== src/pra_ram.sv =====
// Generic simple dual-port RAM with registered read.
module pra_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/pra_datapath.sv =====
// Datapath: config registers, page bitmap, run scanner, write pass and result register.
module pra_datapath #(
	parameter int MAP_PAGES = pra_pkg::MAP_PAGES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pra_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pra_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [1:0]                      kind,
	input  logic [31:0]                     byte_address,
	input  logic [31:0]                     byte_count,
	input  logic                            reverse_search,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [1:0]                      status,
	output logic [31:0]                     granted_address,
	output logic [2:0]                      stat_index,
	output logic [pra_pkg::STAT_W-1:0]      stat_value,
	output logic                            last,
	input  pra_pkg::cmd_t                   cmd,
	output pra_pkg::sts_t                   sts
);

	localparam int AW = $clog2(MAP_PAGES);
	localparam int PW = $clog2(MAP_PAGES + 1);

	// configuration
	logic [31:0]                   base_q;
	logic [pra_pkg::SHIFT_W-1:0]   shift_q;
	logic [pra_pkg::COUNT_W-1:0]   pcount_q;
	logic                          cfg_restart;
	logic [PW-1:0]                 n_w;
	logic [pra_pkg::SHIFT_W-1:0]   sh_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			shift_q  <= pra_pkg::SHIFT_RST;
			pcount_q <= pra_pkg::COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pra_pkg::REG_REGION_BASE: base_q <= cfg_data;
				pra_pkg::REG_PAGE_SHIFT: shift_q <= cfg_data[pra_pkg::SHIFT_W-1:0];
				pra_pkg::REG_PAGE_COUNT: pcount_q <= cfg_data[pra_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_restart = cfg_we && (cfg_index == pra_pkg::REG_PAGE_COUNT);

	always_comb begin
		if (pcount_q == '0) begin
			n_w = PW'(1);
		end else if (32'(pcount_q) > 32'(MAP_PAGES)) begin
			n_w = PW'(MAP_PAGES);
		end else begin
			n_w = PW'(pcount_q);
		end
		if (shift_q < pra_pkg::SHIFT_MIN) begin
			sh_w = pra_pkg::SHIFT_MIN;
		end else if (shift_q > pra_pkg::SHIFT_MAX) begin
			sh_w = pra_pkg::SHIFT_MAX;
		end else begin
			sh_w = shift_q;
		end
	end

	// request capture and range decode
	logic [1:0]              kind_q;
	logic [31:0]             addr_q;
	logic [31:0]             bytes_q;
	logic                    rev_q;
	logic [pra_pkg::PG_W-1:0] pg_q;
	logic [31:0]             al_q;
	logic                    below_q;
	logic [31:0]             start_q;
	logic [32:0]             mask_w;
	logic [31:0]             al_w;
	logic [31:0]             asel_w;
	logic                    bad_w;
	logic [PW-1:0]           pg_n;
	logic [PW-1:0]           start_n;

	assign mask_w = (33'd1 << sh_w) - 33'd1;
	assign al_w   = addr_q & ~mask_w[31:0];
	assign asel_w = (kind_q == pra_pkg::KIND_AT) ? al_w : addr_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind;
			addr_q  <= byte_address;
			bytes_q <= byte_count;
			rev_q   <= reverse_search;
		end
		if (cmd.prep) begin
			pg_q    <= pra_pkg::PG_W'(({1'b0, bytes_q} + mask_w) >> sh_w);
			al_q    <= al_w;
			below_q <= asel_w < base_q;
			start_q <= (asel_w - base_q) >> sh_w;
		end
	end

	assign bad_w = (bytes_q == '0) || (33'(pg_q) > 33'(n_w)) ||
		((kind_q != pra_pkg::KIND_BEST) &&
		(below_q || ((33'(start_q) + 33'(pg_q)) > 33'(n_w))));
	assign pg_n    = pg_q[PW-1:0];
	assign start_n = start_q[PW-1:0];

	// page bitmap, one alloc bit per page
	logic          ram_we;
	logic          ram_wdata;
	logic [0:0]    ram_rdata;
	logic [PW-1:0] rd_p_q;
	logic [PW-1:0] wp_q;

	pra_ram #(
		.WIDTH(1),
		.DEPTH(MAP_PAGES)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wp_q[AW-1:0]),
		.wdata(ram_wdata),
		.raddr(rd_p_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	// run scanner: one page a beat, map reads are registered
	logic          rv_s1;
	logic [PW-1:0] idx_s1;
	logic          run_act_q;
	logic          cur_st_q;
	logic [PW-1:0] cur_len_q;
	logic [PW-1:0] rstart_q;
	logic [PW-1:0] hi_q;
	logic [PW-1:0] lf_q, sf_q, la_q, sa_q, na_q, nf_q;
	logic          found_q;
	logic [PW-1:0] best_q;
	logic [PW-1:0] best_len_q;
	logic [PW-1:0] cnt_q;
	logic          bit_w;
	logic          issue_w;
	logic          chg_w;
	logic          close_w;
	logic          better_w;
	logic          whole_map_w;

	assign bit_w       = ram_rdata[0];
	assign issue_w     = cmd.scan_en && (rd_p_q < hi_q);
	assign chg_w       = rv_s1 && run_act_q && (bit_w != cur_st_q);
	assign close_w     = chg_w || (cmd.close_run && run_act_q);
	assign whole_map_w = (kind_q == pra_pkg::KIND_STAT) || (kind_q == pra_pkg::KIND_BEST);
	assign better_w    = (cur_len_q >= pg_n) && (!found_q ||
		(rev_q ? (cur_len_q <= best_len_q) : (cur_len_q < best_len_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1     <= 1'b0;
			run_act_q <= 1'b0;
		end else begin
			rv_s1 <= issue_w;
			if (cmd.scan_init || cmd.close_run) begin
				run_act_q <= 1'b0;
			end else if (rv_s1) begin
				run_act_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_p_q;
		if (cmd.scan_init) begin
			rd_p_q     <= whole_map_w ? '0 : start_n;
			hi_q       <= whole_map_w ? n_w : start_n + pg_n;
			lf_q       <= '0;
			sf_q       <= '0;
			la_q       <= '0;
			sa_q       <= '0;
			na_q       <= '0;
			nf_q       <= '0;
			found_q    <= 1'b0;
			best_q     <= '0;
			best_len_q <= '0;
			cnt_q      <= '0;
		end else begin
			if (issue_w) begin
				rd_p_q <= rd_p_q + PW'(1);
			end
			if (rv_s1) begin
				cnt_q <= cnt_q + PW'(bit_w);
				if (!run_act_q || chg_w) begin
					cur_st_q  <= bit_w;
					cur_len_q <= PW'(1);
					rstart_q  <= idx_s1;
				end else begin
					cur_len_q <= cur_len_q + PW'(1);
				end
			end
			if (close_w) begin
				if (cur_st_q) begin
					if (cur_len_q > la_q) begin
						la_q <= cur_len_q;
					end
					if ((sa_q == '0) || (cur_len_q < sa_q)) begin
						sa_q <= cur_len_q;
					end
					na_q <= na_q + PW'(1);
				end else begin
					if (cur_len_q > lf_q) begin
						lf_q <= cur_len_q;
					end
					if ((sf_q == '0) || (cur_len_q < sf_q)) begin
						sf_q <= cur_len_q;
					end
					nf_q <= nf_q + PW'(1);
					if (better_w) begin
						found_q    <= 1'b1;
						best_q     <= rstart_q;
						best_len_q <= cur_len_q;
					end
				end
			end
		end
	end

	// write pass and map clear
	logic          wr_fill_q;
	logic [PW-1:0] wr_hi_q;
	logic [PW-1:0] hi_eff_w;
	logic          wr_done_w;
	logic [PW-1:0] free_q;

	assign hi_eff_w  = wr_fill_q ? n_w : wr_hi_q;
	assign wr_done_w = wp_q >= hi_eff_w;
	assign ram_we    = cmd.wr_en && !wr_done_w;
	assign ram_wdata = !wr_fill_q && (kind_q != pra_pkg::KIND_FREE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wr_fill_q <= 1'b1;
		end else if (cmd.fill_init) begin
			wp_q      <= '0;
			wr_fill_q <= 1'b1;
		end else if (cmd.wr_init) begin
			wp_q      <= (kind_q == pra_pkg::KIND_BEST) ? best_q : start_n;
			wr_fill_q <= 1'b0;
		end else if (ram_we) begin
			wp_q <= wp_q + PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_init) begin
			wr_hi_q <= ((kind_q == pra_pkg::KIND_BEST) ? best_q : start_n) + pg_n;
		end
		if (cmd.commit) begin
			if (wr_fill_q) begin
				free_q <= n_w;
			end else if (kind_q == pra_pkg::KIND_FREE) begin
				free_q <= free_q + cnt_q;
			end else begin
				free_q <= free_q - pg_n;
			end
		end
	end

	// result register
	logic                      out_valid_q;
	logic [1:0]                status_q;
	logic [31:0]               addr_out_q;
	logic [2:0]                sidx_q;
	logic [pra_pkg::STAT_W-1:0] sval_q;
	logic                      last_q;
	logic [PW-1:0]             stat_mux_w;
	logic [31:0]               grant_w;

	always_comb begin
		case (cmd.stat_idx)
			pra_pkg::STAT_FREE_PAGES: stat_mux_w = free_q;
			pra_pkg::STAT_LARGE_FREE: stat_mux_w = lf_q;
			pra_pkg::STAT_SMALL_FREE: stat_mux_w = sf_q;
			pra_pkg::STAT_LARGE_ALLOC: stat_mux_w = la_q;
			pra_pkg::STAT_SMALL_ALLOC: stat_mux_w = sa_q;
			pra_pkg::STAT_ALLOC_RUNS: stat_mux_w = na_q;
			pra_pkg::STAT_FREE_RUNS: stat_mux_w = nf_q;
			default: stat_mux_w = '0;
		endcase
		case (kind_q)
			pra_pkg::KIND_BEST: grant_w = base_q + (32'(best_q) << sh_w);
			pra_pkg::KIND_AT: grant_w = al_q;
			default: grant_w = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.res)
				pra_pkg::RES_OK: begin
					status_q   <= pra_pkg::ST_DONE;
					addr_out_q <= grant_w;
					sidx_q     <= '0;
					sval_q     <= '0;
					last_q     <= 1'b1;
				end
				pra_pkg::RES_NOSPACE: begin
					status_q   <= pra_pkg::ST_NOSPACE;
					addr_out_q <= '0;
					sidx_q     <= '0;
					sval_q     <= '0;
					last_q     <= 1'b1;
				end
				pra_pkg::RES_STAT: begin
					status_q   <= pra_pkg::ST_DONE;
					addr_out_q <= '0;
					sidx_q     <= cmd.stat_idx;
					sval_q     <= pra_pkg::STAT_W'(stat_mux_w);
					last_q     <= cmd.stat_idx == pra_pkg::STAT_FREE_RUNS;
				end
				default: begin
					status_q   <= pra_pkg::ST_BAD;
					addr_out_q <= '0;
					sidx_q     <= '0;
					sval_q     <= '0;
					last_q     <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign granted_address = addr_out_q;
	assign stat_index      = sidx_q;
	assign stat_value      = sval_q;
	assign last            = last_q;

	assign sts.kind        = kind_q;
	assign sts.bad         = bad_w;
	assign sts.scan_done   = !(rd_p_q < hi_q) && !rv_s1;
	assign sts.wr_done     = wr_done_w;
	assign sts.found       = found_q;
	assign sts.conflict    = cnt_q != '0;
	assign sts.out_free    = !out_valid_q || out_ready;
	assign sts.cfg_restart = cfg_restart;

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!wr_fill_q |-> free_q <= n_w)
		else $error("free page total exceeds page count");

	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> wp_q < n_w)
		else $error("map write beyond page count");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !cmd.scan_en)
		else $error("map write during scan");

endmodule

// ===== src/pra_ctrl.sv =====
// Request sequencer: drives the datapath through decode, scan, write and result beats.
module pra_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pra_pkg::sts_t sts,
	output pra_pkg::cmd_t cmd
);

	pra_pkg::state_t state_q;
	pra_pkg::state_t state_nxt;
	pra_pkg::res_t   res_q;
	pra_pkg::res_t   res_val;
	logic            res_set;
	logic [2:0]      stat_idx_q;
	logic            stat_clr;
	logic            stat_inc;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			pra_pkg::S_FILL: if (sts.wr_done) state_nxt = pra_pkg::S_IDLE;
			pra_pkg::S_IDLE: if (in_valid) state_nxt = pra_pkg::S_PREP;
			pra_pkg::S_PREP: state_nxt = pra_pkg::S_CHECK;
			pra_pkg::S_CHECK: begin
				if (sts.kind != pra_pkg::KIND_STAT && sts.bad) begin
					state_nxt = pra_pkg::S_RESP;
				end else begin
					state_nxt = pra_pkg::S_SCAN;
				end
			end
			pra_pkg::S_SCAN: if (sts.scan_done) state_nxt = pra_pkg::S_CLOSE;
			pra_pkg::S_CLOSE: state_nxt = pra_pkg::S_DECIDE;
			pra_pkg::S_DECIDE: begin
				case (sts.kind)
					pra_pkg::KIND_STAT: state_nxt = pra_pkg::S_STAT;
					pra_pkg::KIND_BEST:
						state_nxt = sts.found ? pra_pkg::S_WRITE : pra_pkg::S_RESP;
					pra_pkg::KIND_AT:
						state_nxt = sts.conflict ? pra_pkg::S_RESP : pra_pkg::S_WRITE;
					default: state_nxt = pra_pkg::S_WRITE;
				endcase
			end
			pra_pkg::S_WRITE: if (sts.wr_done) state_nxt = pra_pkg::S_RESP;
			pra_pkg::S_RESP: if (sts.out_free) state_nxt = pra_pkg::S_IDLE;
			pra_pkg::S_STAT: begin
				if (sts.out_free && stat_idx_q == pra_pkg::STAT_FREE_RUNS) begin
					state_nxt = pra_pkg::S_IDLE;
				end
			end
			default: state_nxt = pra_pkg::S_FILL;
		endcase
		// a page count write restarts the map from any state
		if (sts.cfg_restart) begin
			state_nxt = pra_pkg::S_FILL;
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.res       = res_q;
		cmd.stat_idx  = stat_idx_q;
		cmd.fill_init = sts.cfg_restart;
		in_ready      = 1'b0;
		res_set       = 1'b0;
		res_val       = pra_pkg::RES_OK;
		stat_clr      = 1'b0;
		stat_inc      = 1'b0;
		case (state_q)
			pra_pkg::S_FILL: begin
				cmd.wr_en  = 1'b1;
				cmd.commit = sts.wr_done;
			end
			pra_pkg::S_IDLE: begin
				in_ready    = !sts.cfg_restart;
				cmd.capture = in_valid && !sts.cfg_restart;
			end
			pra_pkg::S_PREP: cmd.prep = 1'b1;
			pra_pkg::S_CHECK: begin
				if (sts.kind != pra_pkg::KIND_STAT && sts.bad) begin
					res_set = 1'b1;
					res_val = pra_pkg::RES_BAD;
				end else begin
					cmd.scan_init = 1'b1;
				end
			end
			pra_pkg::S_SCAN: cmd.scan_en = 1'b1;
			pra_pkg::S_CLOSE: cmd.close_run = 1'b1;
			pra_pkg::S_DECIDE: begin
				case (sts.kind)
					pra_pkg::KIND_STAT: stat_clr = 1'b1;
					pra_pkg::KIND_BEST: begin
						cmd.wr_init = sts.found;
						res_set     = !sts.found;
						res_val     = pra_pkg::RES_NOSPACE;
					end
					pra_pkg::KIND_AT: begin
						cmd.wr_init = !sts.conflict;
						res_set     = sts.conflict;
						res_val     = pra_pkg::RES_NOSPACE;
					end
					default: cmd.wr_init = 1'b1;
				endcase
			end
			pra_pkg::S_WRITE: begin
				cmd.wr_en  = 1'b1;
				cmd.commit = sts.wr_done;
				res_set    = sts.wr_done;
				res_val    = pra_pkg::RES_OK;
			end
			pra_pkg::S_RESP: cmd.out_load = sts.out_free;
			pra_pkg::S_STAT: begin
				cmd.out_load = sts.out_free;
				cmd.res      = pra_pkg::RES_STAT;
				stat_inc     = sts.out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pra_pkg::S_FILL;
			res_q      <= pra_pkg::RES_OK;
			stat_idx_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (res_set) begin
				res_q <= res_val;
			end
			if (stat_clr) begin
				stat_idx_q <= '0;
			end else if (stat_inc) begin
				stat_idx_q <= stat_idx_q + 3'd1;
			end
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result beat overwritten");

	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == pra_pkg::S_PREP)
		else $error("accepted beat not decoded");

	a_stat_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pra_pkg::S_STAT && sts.out_free && !sts.cfg_restart &&
		stat_idx_q == pra_pkg::STAT_FREE_RUNS) |=> state_q == pra_pkg::S_IDLE)
		else $error("statistics burst did not end");

	a_scan_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pra_pkg::S_SCAN && !sts.scan_done) |=>
		(state_q == pra_pkg::S_SCAN || state_q == pra_pkg::S_FILL))
		else $error("scan left early");

endmodule

// ===== src/page_run_allocator_unit.sv =====
// Top level of the best-fit page run allocator.
//
// Requests come in on in_valid/in_ready (kind, byte_address, byte_count,
// reverse_search); results leave on out_valid/out_ready. Kinds 0..2 give one
// beat; statistics give seven beats, stat_index 0..6, last on the seventh.
// One request is in work at a time; the next is taken once the sequencer is
// back in idle, even while the previous result beat still waits.
// Best fit and statistics walk the whole map, one page per cycle through the
// map RAM read port; a grant then writes the granted pages. Allocate at
// address and free read then rewrite the addressed pages (allocate at address
// only reads when it hits a used page). Bad-range answers go straight to the
// result. in_ready rises with out_valid (with the last beat for statistics).
// Reset and every page_count write clear the map, one page per cycle through
// the RAM write port; in_ready stays low meanwhile.
// A stalled receiver holds the result register; the sequencer waits with it.
// Config writes (cfg_we, cfg_index, cfg_data) belong in idle with no beat in
// flight; the block does not hold them off.
module page_run_allocator_unit #(
	parameter int MAP_PAGES = pra_pkg::MAP_PAGES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      kind,
	input  logic [31:0]                     byte_address,
	input  logic [31:0]                     byte_count,
	input  logic                            reverse_search,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      status,
	output logic [31:0]                     granted_address,
	output logic [2:0]                      stat_index,
	output logic [pra_pkg::STAT_W-1:0]      stat_value,
	output logic                            last,
	input  logic                            cfg_we,
	input  logic [pra_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pra_pkg::CFG_DATA_W-1:0]  cfg_data
);

	pra_pkg::cmd_t cmd;
	pra_pkg::sts_t sts;

	pra_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	pra_datapath #(
		.MAP_PAGES(MAP_PAGES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.kind           (kind),
		.byte_address   (byte_address),
		.byte_count     (byte_count),
		.reverse_search (reverse_search),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.status         (status),
		.granted_address(granted_address),
		.stat_index     (stat_index),
		.stat_value     (stat_value),
		.last           (last),
		.cmd            (cmd),
		.sts            (sts)
	);

endmodule
